[sv/ccs_pkg.sv]
// Shared constants, types and a helper function for the candidate config selector.
package ccs_pkg;

  // Table geometry
  localparam int NUM_CANDIDATES = 64;
  localparam int PARAM_WORDS    = 4;
  localparam int PARAM_BITS     = 16;
  localparam int INDEX_SPACE    = 64;
  localparam int TABLE_DEPTH    = (NUM_CANDIDATES < INDEX_SPACE) ? NUM_CANDIDATES : INDEX_SPACE;
  localparam int VEC_BITS       = PARAM_WORDS * PARAM_BITS;
  localparam int TBL_AW         = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int ACT_W      = 3;
  localparam int IDX_W      = 6;
  localparam int N_W        = 7;
  localparam int VAL_W      = 64;
  localparam int STEP_W     = 10;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] STEP_MAX  = 10'd1023;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_STEP    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUCCESS = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FAILURE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESET   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_JUMP    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 2'd2;

  typedef struct packed {
    logic                en;
    logic [TBL_AW-1:0]   addr;
    logic [VEC_BITS-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic              start;
    logic [LFSR_W-1:0] dividend;
    logic [N_W-1:0]    divisor;
  } mod_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] remainder;
  } mod_rsp_t;

  // Galois right-shift LFSR advance by one position
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

[sv/ccs_table.sv]
// Candidate vector memory with one write port, one registered read port and written flags.
module ccs_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccs_pkg::tbl_wr_t              wr,
  input  ccs_pkg::tbl_rd_t              rd,
  output logic [ccs_pkg::VEC_BITS-1:0]  rd_data
);

  logic [ccs_pkg::VEC_BITS-1:0]    mem [ccs_pkg::TABLE_DEPTH];
  logic [ccs_pkg::TABLE_DEPTH-1:0] written_r;
  logic [ccs_pkg::VEC_BITS-1:0]    rd_data_r;
  logic                            rd_hit_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // Track which entries hold data; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        written_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_hit_r <= written_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

[sv/ccs_mod.sv]
// Iterative restoring remainder unit, one dividend bit per cycle.
module ccs_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  ccs_pkg::mod_req_t req,
  output ccs_pkg::mod_rsp_t rsp
);

  localparam int CW = $clog2(ccs_pkg::LFSR_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [ccs_pkg::LFSR_W-1:0]  dvd_r, dvd_nxt;
  logic [ccs_pkg::N_W-1:0]     dvs_r, dvs_nxt;
  logic [ccs_pkg::N_W-1:0]     rem_r, rem_nxt;
  logic [ccs_pkg::N_W:0]       trial;

  // Shift in one bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[ccs_pkg::LFSR_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ccs_pkg::N_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[ccs_pkg::N_W-1:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(ccs_pkg::LFSR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

[sv/candidate_config_selector.sv]
// Candidate config selector: table of parameter vectors with step/mark/jump/load control.
//
// Input channel (in_valid/in_stall) carries one request: an action code, an entry index
// and a packed 64-bit candidate vector. Every request gives exactly one result on the
// output channel (out_valid/out_stall): current index, held vector, valid count,
// exhausted flag, saturating step count and a rejected flag for out-of-range jump/load.
// Configuration (random mode, active count n, LFSR seed) is written on cfg_valid/cfg_ready
// (always high), by the user only while no request is in flight; the block has no check for it.
// One request at a time; the next can be accepted in the same cycle that out_valid rises.
// Each request counts the valid bits of the n active entries, one per cycle. The remainder
// unit is used once for the start index of a step and, in random mode with valid entries,
// once for the random pick. in_stall is high from accept until the block returns to idle;
// a finished result waits in the output register while the next request is taken, and the
// block holds before delivering a new one while the waiting result is stalled by out_stall.
// Reset clears the output, sets all valid bits, clears the selection, held vector and step
// count, loads the LFSR with the seed and makes every table entry read as zero.
module candidate_config_selector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ccs_pkg::ACT_W-1:0]       in_action,
  input  logic [ccs_pkg::IDX_W-1:0]       in_entry_index,
  input  logic [ccs_pkg::VAL_W-1:0]       in_candidate_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ccs_pkg::IDX_W-1:0]       out_pick_index,
  output logic [ccs_pkg::VAL_W-1:0]       out_current_values,
  output logic [ccs_pkg::N_W-1:0]         out_valid_count,
  output logic                            out_exhausted,
  output logic [ccs_pkg::STEP_W-1:0]      out_tried_count,
  output logic                            out_rejected,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = ccs_pkg::TBL_AW;
  localparam int NW = ccs_pkg::N_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_COUNT  = 9'b000000100,
    S_MODS   = 9'b000001000,
    S_MODK   = 9'b000010000,
    S_PICK   = 9'b000100000,
    S_READ   = 9'b001000000,
    S_LOAD   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ccs_pkg::ACT_W-1:0]           act_r, act_nxt;
  logic [ccs_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic [ccs_pkg::VAL_W-1:0]           val_r, val_nxt;
  logic [NW-1:0]                       n_r, n_nxt;
  logic                                random_mode_r, random_mode_nxt;
  logic [NW-1:0]                       active_r, active_nxt;
  logic [ccs_pkg::LFSR_W-1:0]          seed_r, seed_nxt;
  logic [ccs_pkg::TABLE_DEPTH-1:0]     valid_r, valid_nxt;
  logic [ccs_pkg::IDX_W-1:0]           sel_r, sel_nxt;
  logic [ccs_pkg::VAL_W-1:0]           held_r, held_nxt;
  logic [ccs_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic [ccs_pkg::LFSR_W-1:0]          lfsr_r, lfsr_nxt;
  logic [NW-1:0]                       vc_r, vc_nxt;
  logic [NW-1:0]                       cnt_r, cnt_nxt;
  logic [AW-1:0]                       scan_r, scan_nxt;
  logic [NW-1:0]                       seen_r, seen_nxt;
  logic [AW-1:0]                       base_r, base_nxt;
  logic [NW-1:0]                       k_r, k_nxt;
  logic                                rej_r, rej_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [ccs_pkg::IDX_W-1:0]           out_idx_r, out_idx_nxt;
  logic [ccs_pkg::VAL_W-1:0]           out_vals_r, out_vals_nxt;
  logic [NW-1:0]                       out_vc_r, out_vc_nxt;
  logic [ccs_pkg::STEP_W-1:0]          out_step_r, out_step_nxt;
  logic                                out_rej_r, out_rej_nxt;

  logic [NW-1:0]                       n_clamped;
  logic [ccs_pkg::LFSR_W-1:0]          seed_eff;
  logic [NW-1:0]                       n_last;
  logic [NW-1:0]                       scan_inc;
  logic [AW-1:0]                       scan_wrap;
  logic [NW-1:0]                       rem_inc;

  ccs_pkg::tbl_wr_t                    tbl_wr;
  ccs_pkg::tbl_rd_t                    tbl_rd;
  logic [ccs_pkg::VEC_BITS-1:0]        tbl_rd_data;
  ccs_pkg::mod_req_t                   mod_req;
  ccs_pkg::mod_rsp_t                   mod_rsp;

  ccs_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_rd_data)
  );

  ccs_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // Clamp active count to 1..TABLE_DEPTH, force a nonzero seed
  assign n_clamped = (active_r == '0) ? NW'(1) :
                     (active_r > NW'(ccs_pkg::TABLE_DEPTH)) ? NW'(ccs_pkg::TABLE_DEPTH) :
                     active_r;
  assign seed_eff  = (seed_r == '0) ? ccs_pkg::LFSR_W'(1) : seed_r;
  assign n_last    = n_r - NW'(1);
  assign scan_inc  = {1'b0, scan_r} + NW'(1);
  assign scan_wrap = (scan_inc == n_r) ? '0 : scan_inc[AW-1:0];
  assign rem_inc   = mod_rsp.remainder + NW'(1);

  // Request sequencer
  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    idx_nxt         = idx_r;
    val_nxt         = val_r;
    n_nxt           = n_r;
    random_mode_nxt = random_mode_r;
    active_nxt      = active_r;
    seed_nxt        = seed_r;
    valid_nxt       = valid_r;
    sel_nxt         = sel_r;
    held_nxt        = held_r;
    step_nxt        = step_r;
    lfsr_nxt        = lfsr_r;
    vc_nxt          = vc_r;
    cnt_nxt         = cnt_r;
    scan_nxt        = scan_r;
    seen_nxt        = seen_r;
    base_nxt        = base_r;
    k_nxt           = k_r;
    rej_nxt         = rej_r;
    out_valid_nxt   = out_valid_r;
    out_idx_nxt     = out_idx_r;
    out_vals_nxt    = out_vals_r;
    out_vc_nxt      = out_vc_r;
    out_step_nxt    = out_step_r;
    out_rej_nxt     = out_rej_r;
    tbl_wr          = '0;
    tbl_rd          = '0;
    mod_req         = '0;

    // Take configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        ccs_pkg::CFG_RANDOM_MODE: random_mode_nxt = cfg_data[0];
        ccs_pkg::CFG_ACTIVE:      active_nxt      = cfg_data[NW-1:0];
        ccs_pkg::CFG_SEED:        seed_nxt        = cfg_data[ccs_pkg::LFSR_W-1:0];
        default: ;
      endcase
    end

    // Drop a delivered result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          idx_nxt   = in_entry_index;
          val_nxt   = in_candidate_value;
          n_nxt     = n_clamped;
          state_nxt = S_DECODE;
        end
      end

      // Apply the immediate part of the request
      S_DECODE: begin
        rej_nxt   = 1'b0;
        cnt_nxt   = '0;
        vc_nxt    = '0;
        state_nxt = S_COUNT;
        case (act_r)
          ccs_pkg::ACT_STEP: begin
            if (step_r != ccs_pkg::STEP_MAX) begin
              step_nxt = step_r + ccs_pkg::STEP_W'(1);
            end
            if (random_mode_r) begin
              lfsr_nxt = ccs_pkg::lfsr_next(lfsr_r);
            end
          end
          ccs_pkg::ACT_SUCCESS: begin
            if ({1'b0, sel_r} < NW'(ccs_pkg::TABLE_DEPTH)) begin
              valid_nxt[sel_r[AW-1:0]] = 1'b1;
            end
          end
          ccs_pkg::ACT_FAILURE: begin
            if ({1'b0, sel_r} < NW'(ccs_pkg::TABLE_DEPTH)) begin
              valid_nxt[sel_r[AW-1:0]] = 1'b0;
            end
          end
          ccs_pkg::ACT_RESET: begin
            valid_nxt = '1;
            step_nxt  = '0;
            sel_nxt   = '0;
            lfsr_nxt  = seed_eff;
          end
          ccs_pkg::ACT_JUMP: begin
            if ({1'b0, idx_r} < n_r) begin
              sel_nxt = idx_r;
            end else begin
              rej_nxt = 1'b1;
            end
          end
          ccs_pkg::ACT_LOAD: begin
            if ({1'b0, idx_r} < n_r) begin
              tbl_wr.en   = 1'b1;
              tbl_wr.addr = idx_r[AW-1:0];
              tbl_wr.data = val_r[ccs_pkg::VEC_BITS-1:0];
            end else begin
              rej_nxt = 1'b1;
            end
          end
          ccs_pkg::ACT_QUERY: ;
          default: ;
        endcase
      end

      // Count valid bits among the active entries, one per cycle
      S_COUNT: begin
        vc_nxt  = vc_r + NW'(valid_r[cnt_r[AW-1:0]]);
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == n_last) begin
          case (act_r)
            ccs_pkg::ACT_STEP: begin
              mod_req.start    = 1'b1;
              mod_req.dividend = ccs_pkg::LFSR_W'(sel_r);
              mod_req.divisor  = n_r;
              state_nxt        = S_MODS;
            end
            ccs_pkg::ACT_RESET: state_nxt = S_READ;
            ccs_pkg::ACT_JUMP:  state_nxt = rej_r ? S_DONE : S_READ;
            default:            state_nxt = S_DONE;
          endcase
        end
      end

      // Start index is the selection modulo n
      S_MODS: begin
        if (mod_rsp.done) begin
          base_nxt = mod_rsp.remainder[AW-1:0];
          if (random_mode_r) begin
            if (vc_r == '0) begin
              sel_nxt   = (mod_rsp.remainder == n_last) ? '0 : ccs_pkg::IDX_W'(rem_inc);
              state_nxt = S_READ;
            end else begin
              mod_req.start    = 1'b1;
              mod_req.dividend = lfsr_r;
              mod_req.divisor  = vc_r;
              state_nxt        = S_MODK;
            end
          end else if (n_r == NW'(1)) begin
            sel_nxt   = ccs_pkg::IDX_W'(mod_rsp.remainder);
            state_nxt = S_READ;
          end else begin
            scan_nxt  = mod_rsp.remainder[AW-1:0];
            cnt_nxt   = NW'(1);
            state_nxt = S_PICK;
          end
        end
      end

      // Pick rank is the LFSR value modulo the valid count
      S_MODK: begin
        if (mod_rsp.done) begin
          k_nxt     = mod_rsp.remainder;
          scan_nxt  = '0;
          seen_nxt  = '0;
          state_nxt = S_PICK;
        end
      end

      // Walk the valid bits one entry per cycle
      S_PICK: begin
        if (random_mode_r) begin
          if (valid_r[scan_r] && seen_r == k_r) begin
            sel_nxt   = ccs_pkg::IDX_W'(scan_r);
            state_nxt = S_READ;
          end else if ({1'b0, scan_r} == n_last) begin
            sel_nxt   = ccs_pkg::IDX_W'(base_r);
            state_nxt = S_READ;
          end else begin
            if (valid_r[scan_r]) begin
              seen_nxt = seen_r + NW'(1);
            end
            scan_nxt = scan_inc[AW-1:0];
          end
        end else begin
          if (valid_r[scan_wrap]) begin
            sel_nxt   = ccs_pkg::IDX_W'(scan_wrap);
            state_nxt = S_READ;
          end else if (cnt_r == n_last) begin
            sel_nxt   = ccs_pkg::IDX_W'(base_r);
            state_nxt = S_READ;
          end else begin
            scan_nxt = scan_wrap;
            cnt_nxt  = cnt_r + NW'(1);
          end
        end
      end

      // Fetch the selected vector
      S_READ: begin
        tbl_rd.en   = 1'b1;
        tbl_rd.addr = sel_r[AW-1:0];
        state_nxt   = S_LOAD;
      end

      S_LOAD: begin
        held_nxt  = ccs_pkg::VAL_W'(tbl_rd_data);
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = sel_r;
          out_vals_nxt  = held_r;
          out_vc_nxt    = vc_r;
          out_step_nxt  = step_r;
          out_rej_nxt   = rej_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      random_mode_r <= 1'b1;
      active_r      <= NW'(64);
      seed_r        <= ccs_pkg::LFSR_W'(1);
      valid_r       <= '1;
      sel_r         <= '0;
      held_r        <= '0;
      step_r        <= '0;
      lfsr_r        <= ccs_pkg::LFSR_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      random_mode_r <= random_mode_nxt;
      active_r      <= active_nxt;
      seed_r        <= seed_nxt;
      valid_r       <= valid_nxt;
      sel_r         <= sel_nxt;
      held_r        <= held_nxt;
      step_r        <= step_nxt;
      lfsr_r        <= lfsr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    n_r        <= n_nxt;
    vc_r       <= vc_nxt;
    cnt_r      <= cnt_nxt;
    scan_r     <= scan_nxt;
    seen_r     <= seen_nxt;
    base_r     <= base_nxt;
    k_r        <= k_nxt;
    rej_r      <= rej_nxt;
    out_idx_r  <= out_idx_nxt;
    out_vals_r <= out_vals_nxt;
    out_vc_r   <= out_vc_nxt;
    out_step_r <= out_step_nxt;
    out_rej_r  <= out_rej_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_pick_index     = out_idx_r;
  assign out_current_values = out_vals_r;
  assign out_valid_count    = out_vc_r;
  assign out_exhausted      = (out_vc_r == '0);
  assign out_tried_count    = out_step_r;
  assign out_rejected       = out_rej_r;

endmodule

[sv/ccs_checker.sv]
// Port-level checker for the candidate config selector and its bind.
module ccs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ccs_pkg::IDX_W-1:0]   out_pick_index,
  input logic [ccs_pkg::VAL_W-1:0]   out_current_values,
  input logic [ccs_pkg::N_W-1:0]     out_valid_count,
  input logic                        out_exhausted,
  input logic [ccs_pkg::STEP_W-1:0]  out_tried_count
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pick_index) &&
      $stable(out_current_values) && $stable(out_tried_count))
    else $error("stalled result changed");

  // Exhausted flag tracks the valid count
  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exhausted == (out_valid_count == '0)))
    else $error("exhausted flag disagrees with valid count");

  // Valid count never exceeds the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_count <= ccs_pkg::N_W'(ccs_pkg::TABLE_DEPTH)))
    else $error("valid count out of range");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous still in work");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind candidate_config_selector ccs_checker u_ccs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_pick_index     (out_pick_index),
  .out_current_values (out_current_values),
  .out_valid_count    (out_valid_count),
  .out_exhausted      (out_exhausted),
  .out_tried_count    (out_tried_count)
);

[bench/selection_checker.sv]
// Checker for the candidate config selector: mirrors its state, predicts and compares results.
module selection_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ccs_pkg::ACT_W-1:0]      in_action,
  input  logic [ccs_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [ccs_pkg::VAL_W-1:0]      in_candidate_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ccs_pkg::IDX_W-1:0]      out_pick_index,
  input  logic [ccs_pkg::VAL_W-1:0]      out_current_values,
  input  logic [ccs_pkg::N_W-1:0]        out_valid_count,
  input  logic                           out_exhausted,
  input  logic [ccs_pkg::STEP_W-1:0]     out_tried_count,
  input  logic                           out_rejected,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  cur_index;
    logic [VAL_W-1:0]  values;
    logic [N_W-1:0]    live_count;
    logic              exhausted;
    logic [STEP_W-1:0] tried;
    logic              rejected;
  } status_t;

  // Mirrored configuration
  logic              mode_q;
  logic [N_W-1:0]    active_q;
  logic [LFSR_W-1:0] seed_q;

  // Mirrored search state
  logic [VAL_W-1:0]       vectors [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] live;
  logic [IDX_W-1:0]       sel;
  logic [VAL_W-1:0]       held;
  logic [STEP_W-1:0]      steps;
  logic [LFSR_W-1:0]      lfsr;

  status_t pending_status [$];

  // Count valid entries among the first n
  function automatic int live_entries(input int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++) c += live[i];
    return c;
  endfunction

  // Restore valid bits, counters and the pick generator
  function automatic void restart_search();
    live  = '1;
    steps = '0;
    sel   = '0;
    held  = vectors[0];
    lfsr  = (seed_q == '0) ? LFSR_W'(1) : seed_q;
  endfunction

  // Apply one request to the mirror and return the status it should report
  function automatic status_t next_selection_status(input logic [ACT_W-1:0] act,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [VAL_W-1:0] val);
    status_t r;
    int      n, s, vc, k, seen, p, i;
    logic    rej;
    n = int'(active_q);
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    rej = 1'b0;
    case (act)
      ACT_STEP: begin
        s = int'(sel) % n;
        if (steps != STEP_MAX) steps = steps + 1'b1;
        if (mode_q) begin
          vc   = live_entries(n);
          lfsr = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
          if (vc > 0) begin
            k    = int'(lfsr) % vc;
            seen = 0;
            for (i = 0; i < n; i++) begin
              if (live[i]) begin
                if (seen == k) begin
                  s = i;
                  break;
                end
                seen++;
              end
            end
          end else begin
            // nothing valid: move on by one
            s = (s + 1) % n;
          end
        end else begin
          // scan forward with wraparound, stay put if nothing is valid
          p = s;
          for (i = 1; i < n; i++) begin
            p = (p + 1) % n;
            if (live[p]) begin
              s = p;
              break;
            end
          end
        end
        sel  = IDX_W'(s);
        held = vectors[s];
      end
      ACT_SUCCESS: live[sel] = 1'b1;
      ACT_FAILURE: live[sel] = 1'b0;
      ACT_RESET:   restart_search();
      ACT_JUMP: begin
        if (int'(idx) < n) begin
          sel  = idx;
          held = vectors[idx];
        end else begin
          rej = 1'b1;
        end
      end
      ACT_LOAD: begin
        if (int'(idx) < n) vectors[idx] = val;
        else rej = 1'b1;
      end
      default: ;
    endcase
    vc           = live_entries(n);
    r.cur_index  = sel;
    r.values     = held;
    r.live_count = N_W'(vc);
    r.exhausted  = (vc == 0);
    r.tried      = steps;
    r.rejected   = rej;
    return r;
  endfunction

  // Track configuration, check results, queue predictions
  always @(posedge clk) begin : watch
    status_t got, want;
    if (!rst_n) begin
      mode_q   = 1'b1;
      active_q = N_W'(64);
      seed_q   = LFSR_W'(1);
      foreach (vectors[i]) vectors[i] = '0;
      restart_search();
      held = '0;
      pending_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RANDOM_MODE: mode_q   = cfg_data[0];
          CFG_ACTIVE:      active_q = cfg_data[N_W-1:0];
          CFG_SEED:        seed_q   = cfg_data[LFSR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_pick_index, out_current_values, out_valid_count, out_exhausted,
                out_tried_count, out_rejected};
        if (pending_status.size() == 0) begin
          $error("result arrived with no request waiting");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          if (got.cur_index !== want.cur_index) begin
            $error("pick_index expected %0d actual %0d", want.cur_index, got.cur_index);
            fail_count++;
          end
          if (got.values !== want.values) begin
            $error("current_values expected %h actual %h", want.values, got.values);
            fail_count++;
          end
          if (got.live_count !== want.live_count) begin
            $error("valid_count expected %0d actual %0d", want.live_count, got.live_count);
            fail_count++;
          end
          if (got.exhausted !== want.exhausted) begin
            $error("exhausted expected %0d actual %0d", want.exhausted, got.exhausted);
            fail_count++;
          end
          if (got.tried !== want.tried) begin
            $error("tried_count expected %0d actual %0d", want.tried, got.tried);
            fail_count++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected expected %0d actual %0d", want.rejected, got.rejected);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_status.push_back(
          next_selection_status(in_action, in_entry_index, in_candidate_value));
      end
    end
    outstanding = pending_status.size();
  end

endmodule

[bench/testbench.sv]
// Top of the candidate config selector bench: clock, reset, requests, configuration, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;
  localparam int HOLD_CYCLES  = 500;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACT_W-1:0]      in_action;
  logic [IDX_W-1:0]      in_entry_index;
  logic [VAL_W-1:0]      in_candidate_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_W-1:0]      out_pick_index;
  logic [VAL_W-1:0]      out_current_values;
  logic [N_W-1:0]        out_valid_count;
  logic                  out_exhausted;
  logic [STEP_W-1:0]     out_tried_count;
  logic                  out_rejected;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int idle_pct;
  int stall_pct;
  int holds_asked;
  int holds_done;
  int span;
  int quiet_cycles;

  candidate_config_selector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_candidate_value (in_candidate_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pick_index     (out_pick_index),
    .out_current_values (out_current_values),
    .out_valid_count    (out_valid_count),
    .out_exhausted      (out_exhausted),
    .out_tried_count    (out_tried_count),
    .out_rejected       (out_rejected),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  selection_checker mirror (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_candidate_value (in_candidate_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pick_index     (out_pick_index),
    .out_current_values (out_current_values),
    .out_valid_count    (out_valid_count),
    .out_exhausted      (out_exhausted),
    .out_tried_count    (out_tried_count),
    .out_rejected       (out_rejected),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic offer(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                       input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_entry_index     <= idx;
    in_candidate_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every request has reported back
  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // Write one register; valid stays up for the next write
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write all registers and note the effective active count
  task automatic configure(input logic mode, input logic [N_W-1:0] active,
                           input logic [LFSR_W-1:0] seed);
    put_reg(CFG_RANDOM_MODE, CFG_DATA_W'(mode));
    put_reg(CFG_ACTIVE, CFG_DATA_W'(active));
    put_reg(CFG_SEED, seed);
    cfg_valid <= 1'b0;
    span = (active == 0) ? 1 : ((int'(active) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active));
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    out_stall  = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("candidate_config_selector verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    logic [ACT_W-1:0]  act;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic              mode;
    logic [N_W-1:0]    active;
    logic [LFSR_W-1:0] seed;
    int                roll;
    int                count;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_action          = ACT_QUERY;
    in_entry_index     = '0;
    in_candidate_value = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_RANDOM_MODE;
    cfg_data           = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    holds_asked        = 0;
    span               = TABLE_DEPTH;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, table edges, every action
    offer(ACT_QUERY, '0, '0);
    offer(ACT_LOAD, '0, '1);
    offer(ACT_LOAD, 6'd63, 64'h8000_0000_0000_0001);
    offer(ACT_LOAD, 6'd1, 64'h0123_4567_89AB_CDEF);
    offer(ACT_JUMP, 6'd63, '1);
    offer(ACT_STEP, 6'd63, '1);
    offer(ACT_FAILURE, '0, '0);
    offer(ACT_STEP, '0, '0);
    offer(ACT_SUCCESS, '0, '0);
    offer(ACT_JUMP, '0, '0);
    offer(ACT_RESET, '1, '1);
    offer(ACT_SPARE, '1, '1);
    settle();

    // Three entries, sequential, zero seed: mark all bad until exhausted
    configure(1'b0, N_W'(3), '0);
    offer(ACT_JUMP, 6'd5, '0);
    offer(ACT_LOAD, 6'd63, '1);
    offer(ACT_RESET, '0, '0);
    offer(ACT_FAILURE, '0, '0);
    offer(ACT_STEP, '0, '0);
    offer(ACT_FAILURE, '0, '0);
    offer(ACT_STEP, '0, '0);
    offer(ACT_FAILURE, '0, '0);
    offer(ACT_STEP, '0, '0);
    settle();

    // Random mode with nothing valid
    configure(1'b1, N_W'(3), '0);
    offer(ACT_STEP, '0, '0);
    offer(ACT_QUERY, '0, '0);
    offer(ACT_RESET, '0, '0);

    // Random phases: one register setting and one idling pattern each
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin mode = 1'b1; active = N_W'(64);  seed = 16'hFFFF; end
        1: begin mode = 1'b0; active = N_W'(64);  seed = 16'h0000; end
        2: begin mode = 1'b1; active = N_W'(1);   seed = 16'hACE1; end
        3: begin mode = 1'b0; active = N_W'(0);   seed = 16'h5A5A; end
        4: begin mode = 1'b1; active = N_W'(127); seed = 16'h0000; end
        5: begin
          mode   = 1'b0;
          active = N_W'($urandom_range(63, 2));
          seed   = LFSR_W'($urandom);
        end
        6: begin
          mode   = 1'b1;
          active = N_W'($urandom_range(63, 2));
          seed   = LFSR_W'($urandom_range(65535, 1));
        end
        default: begin mode = 1'b1; active = N_W'(2); seed = 16'h8000; end
      endcase
      configure(mode, active, seed);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // Long receiver hold-off while the sender keeps pushing
      if (p % 4 == 0) holds_asked++;
      offer(ACT_RESET, IDX_W'($urandom), {$urandom, $urandom});

      // The long phase never resets, so the step counter saturates
      count = (p == 3) ? 1200 : 100;
      repeat (count) begin
        roll = $urandom_range(99);
        if (p == 3 && $urandom_range(9) != 0) act = ACT_STEP;
        else if (roll < 36) act = ACT_STEP;
        else if (roll < 54) act = ACT_FAILURE;
        else if (roll < 62) act = ACT_SUCCESS;
        else if (roll < 72) act = ACT_JUMP;
        else if (roll < 84) act = ACT_LOAD;
        else if (roll < 89) act = ACT_RESET;
        else if (roll < 96) act = ACT_QUERY;
        else act = ACT_SPARE;
        if (p == 3 && act == ACT_RESET) act = ACT_QUERY;
        if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(span - 1));
        else idx = IDX_W'($urandom_range(63));
        roll = $urandom_range(99);
        if (roll < 5) val = '1;
        else if (roll < 10) val = '0;
        else val = {$urandom, $urandom};
        offer(act, idx, val);
      end
    end

    // Drain, then give stray results time to show up
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("candidate_config_selector verification clean");
    end else begin
      $display("candidate_config_selector verification failed");
    end
    $finish;
  end

endmodule
